// ===== rtl/ide_pkg.sv =====
// Shared types and constants for the interaural delay estimator.
// No dependencies.
`default_nettype none
package ide_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int STORE_W  = 24;
  localparam int DELAY_W  = 32;
  localparam int LAG_W    = 8;
  localparam int OUT_W    = 9;
  localparam int ACC_W    = 60;
  localparam int CORR_W   = 64;

  typedef enum logic [2:0] {
    REG_B0      = 3'd0,
    REG_B1      = 3'd1,
    REG_B2      = 3'd2,
    REG_A1      = 3'd3,
    REG_A2      = 3'd4,
    REG_MAX_LAG = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] itd;
    logic [OUT_W-1:0]        idx;
    logic                    found;
  } corr_result_t;

endpackage
`default_nettype wire

// ===== rtl/interaural_delay_estimator.sv =====
// Top level of the interaural delay estimator: registers, run control, lanes, correlator.
// Depends on ide_pkg, ide_biquad_lane, ide_correlator.
`default_nettype none
// Each request carries a left/right sample pair; the two ears are filtered by two
// biquad lanes in parallel, in 8 steps of each lane's single multiplier. The pair
// marked last closes the run: the stored N pairs are cross-correlated over 2N-1
// lags by one multiply-accumulate unit, and one result carries the clamped lag,
// the peak index, whether a positive peak exists and whether pairs were dropped
// beyond MAX_RESPONSE_LEN. Inputs are not taken during filtering or correlation.
module interaural_delay_estimator #(
  parameter int MAX_RESPONSE_LEN = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ide_pkg::SAMPLE_W-1:0]  left_sample,
  input  logic signed [ide_pkg::SAMPLE_W-1:0]  right_sample,
  input  logic                                 last_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ide_pkg::OUT_W-1:0]     itd_samples,
  output logic [ide_pkg::OUT_W-1:0]            peak_index,
  output logic                                 peak_found,
  output logic                                 length_overflow,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [2:0]                           cfg_index,
  input  logic [ide_pkg::COEF_W-1:0]           cfg_data
);
  import ide_pkg::*;

  localparam int AW = $clog2(MAX_RESPONSE_LEN);
  localparam int CW = $clog2(MAX_RESPONSE_LEN + 1);

  typedef enum logic [3:0] {
    S_IN   = 4'b0001,
    S_FILT = 4'b0010,
    S_CORR = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t        state;
  coef_t         coef;
  logic [LAG_W-1:0] max_lag;
  logic [CW-1:0] count;
  logic          overflow, last_q, clr;
  logic          lane_start, corr_start, l_done, r_done, corr_done;
  logic [CW-1:0] corr_len;
  logic signed [STORE_W-1:0] yl, yr;
  corr_result_t  cres, res_q;
  logic          in_fire, full;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IN);
  assign in_fire   = in_valid && in_ready;
  assign full      = (count == CW'(MAX_RESPONSE_LEN));
  assign lane_start = in_fire && !full;
  assign clr       = (state == S_EMIT) && !out_valid;

  always_comb begin
    corr_start = 1'b0;
    corr_len   = count;
    if (in_fire && full && last_sample) begin
      corr_start = 1'b1;
    end else if (state == S_FILT && l_done && last_q) begin
      corr_start = 1'b1;
      corr_len   = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0 <= 24'sd9444;
      coef.b1 <= 24'sd18889;
      coef.b2 <= 24'sd9444;
      coef.a1 <= -24'sd7807060;
      coef.a2 <= 24'sd3650583;
      max_lag <= 8'd33;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_B0:      coef.b0 <= cfg_data;
        REG_B1:      coef.b1 <= cfg_data;
        REG_B2:      coef.b2 <= cfg_data;
        REG_A1:      coef.a1 <= cfg_data;
        REG_A2:      coef.a2 <= cfg_data;
        REG_MAX_LAG: max_lag <= cfg_data[LAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IN: begin
          if (in_fire) begin
            last_q <= last_sample;
            if (!full) begin
              state <= S_FILT;
            end else begin
              overflow <= 1'b1;
              if (last_sample) state <= S_CORR;
            end
          end
        end
        S_FILT: begin
          if (l_done) begin
            count <= count + CW'(1);
            state <= last_q ? S_CORR : S_IN;
          end
        end
        S_CORR: begin
          if (corr_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            count     <= '0;
            overflow  <= 1'b0;
            state     <= S_IN;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (corr_done) res_q <= cres;
    if (clr) begin
      itd_samples     <= res_q.itd;
      peak_index      <= res_q.idx;
      peak_found      <= res_q.found;
      length_overflow <= overflow;
    end
  end

  ide_biquad_lane u_left (
    .clk(clk), .rst(rst), .clr(clr), .start(lane_start), .x(left_sample),
    .coef(coef), .done(l_done), .y(yl)
  );

  ide_biquad_lane u_right (
    .clk(clk), .rst(rst), .clr(clr), .start(lane_start), .x(right_sample),
    .coef(coef), .done(r_done), .y(yr)
  );

  ide_correlator #(.MAX_RESPONSE_LEN(MAX_RESPONSE_LEN)) u_corr (
    .clk(clk), .rst(rst),
    .wr_en(state == S_FILT && l_done && r_done), .wr_addr(count[AW-1:0]),
    .wr_left(yl), .wr_right(yr),
    .start(corr_start), .n_len(corr_len), .max_lag(max_lag),
    .done(corr_done), .result(cres)
  );

endmodule
`default_nettype wire

// ===== rtl/ide_biquad_lane.sv =====
// One ear's direct-form-II biquad, one shared multiplier stepped over the five products.
// Depends on ide_pkg.
`default_nettype none
module ide_biquad_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clr,
  input  logic                                start,
  input  logic signed [ide_pkg::SAMPLE_W-1:0] x,
  input  ide_pkg::coef_t                      coef,
  output logic                                done,
  output logic signed [ide_pkg::STORE_W-1:0]  y
);
  import ide_pkg::*;

  localparam int PROD_W = COEF_W + DELAY_W;
  localparam int RND_W  = ACC_W - 22;

  logic [3:0]                step;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DELAY_W-1:0] d1, d2, w;
  logic signed [SAMPLE_W-1:0] xq;
  logic signed [COEF_W-1:0]  mc;
  logic signed [DELAY_W-1:0] md;
  logic signed [RND_W-1:0]   rnd;
  logic signed [DELAY_W-1:0] w_sat;

  always_comb begin
    rnd = RND_W'((acc + ACC_W'(64'sd2097152)) >>> 22);
    if (rnd > RND_W'(64'sh7FFFFFFF))
      w_sat = 32'sh7FFFFFFF;
    else if (rnd < -RND_W'(64'sh80000000))
      w_sat = 32'sh80000000;
    else
      w_sat = rnd[DELAY_W-1:0];
    if (rnd > RND_W'(64'sh7FFFFF))
      y = 24'sh7FFFFF;
    else if (rnd < -RND_W'(64'sh800000))
      y = 24'sh800000;
    else
      y = rnd[STORE_W-1:0];
  end

  always_comb begin
    case (step)
      4'd1: begin mc = coef.a1; md = d1; end
      4'd2: begin mc = coef.a2; md = d2; end
      4'd4: begin mc = coef.b1; md = d1; end
      4'd5: begin mc = coef.b0; md = w; end
      4'd6: begin mc = coef.b2; md = d2; end
      default: begin mc = coef.b0; md = w; end
    endcase
  end

  assign done = (step == 4'd8);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 4'd0;
      d1   <= '0;
      d2   <= '0;
    end else begin
      if (start) begin
        step <= 4'd1;
      end else if (step == 4'd8) begin
        step <= 4'd0;
      end else if (step != 4'd0) begin
        step <= step + 4'd1;
      end
      if (clr) begin
        d1 <= '0;
        d2 <= '0;
      end else if (step == 4'd8) begin
        d2 <= d1;
        d1 <= w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) xq <= x;
    prod <= mc * md;
    case (step)
      4'd1: acc <= ACC_W'(xq) <<< 27;
      4'd2: acc <= acc - ACC_W'(prod);
      4'd3: acc <= acc - ACC_W'(prod);
      4'd4: begin
        w   <= w_sat;
        acc <= '0;
      end
      4'd5: acc <= acc + ACC_W'(prod);
      4'd6: acc <= acc + ACC_W'(prod);
      4'd7: acc <= acc + ACC_W'(prod);
      default: acc <= acc;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/ide_correlator.sv =====
// Filtered-sample stores, one MAC over all lags, and the peak merge with lag clamp.
// Depends on ide_pkg.
`default_nettype none
module ide_correlator #(
  parameter int MAX_RESPONSE_LEN = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [$clog2(MAX_RESPONSE_LEN)-1:0] wr_addr,
  input  logic signed [ide_pkg::STORE_W-1:0] wr_left,
  input  logic signed [ide_pkg::STORE_W-1:0] wr_right,
  input  logic                               start,
  input  logic [$clog2(MAX_RESPONSE_LEN+1)-1:0] n_len,
  input  logic [ide_pkg::LAG_W-1:0]          max_lag,
  output logic                               done,
  output ide_pkg::corr_result_t              result
);
  import ide_pkg::*;

  localparam int AW = $clog2(MAX_RESPONSE_LEN);
  localparam int CW = $clog2(MAX_RESPONSE_LEN + 1);
  localparam int JW = $clog2(2 * MAX_RESPONSE_LEN);
  localparam int XW = JW + 1;
  localparam int IW = (JW > OUT_W) ? JW : OUT_W;

  logic signed [STORE_W-1:0] mem_l [MAX_RESPONSE_LEN];
  logic signed [STORE_W-1:0] mem_r [MAX_RESPONSE_LEN];

  logic          running, issuing;
  logic [CW-1:0] nq;
  logic [JW-1:0] j;
  logic [AW-1:0] m, n;
  logic [CW-1:0] cnt;
  logic [XW-1:0] jn, nx, jlast;

  logic          v1, v2, sv, last1, last2, acc_clr;
  logic [JW-1:0] j1, j2, sj;
  logic signed [STORE_W-1:0]   lq, rq;
  logic signed [2*STORE_W-1:0] prod;
  logic signed [CORR_W-1:0]    acc, acc_next, sum, best;
  logic [JW-1:0]               best_idx;
  logic                        found;

  logic signed [XW:0] itd_full, lim;
  logic signed [XW:0] itd_c;
  logic [IW-1:0]      idx_w;

  always_comb begin
    jn    = XW'(j) + XW'(1);
    nx    = XW'(nq);
    jlast = (nx << 1) - XW'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_l[wr_addr] <= wr_left;
      mem_r[wr_addr] <= wr_right;
    end
    lq <= mem_l[m];
    rq <= mem_r[n];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      issuing <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      sv <= 1'b0;
    end else begin
      if (start) begin
        running <= 1'b1;
        issuing <= 1'b1;
      end else if (done) begin
        running <= 1'b0;
      end else if (issuing && cnt == CW'(1) && jn == jlast) begin
        issuing <= 1'b0;
      end
      v1 <= issuing;
      v2 <= v1;
      sv <= v2 && last2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= n_len;
      j   <= '0;
      m   <= '0;
      n   <= AW'(n_len - CW'(1));
      cnt <= CW'(1);
    end else if (issuing) begin
      if (cnt == CW'(1)) begin
        j <= JW'(jn);
        if (jn < nx) begin
          m   <= '0;
          n   <= AW'(nx - XW'(1) - jn);
          cnt <= CW'(jn + XW'(1));
        end else begin
          m   <= AW'(jn - nx + XW'(1));
          n   <= '0;
          cnt <= CW'(jlast - jn);
        end
      end else begin
        m   <= m + AW'(1);
        n   <= n + AW'(1);
        cnt <= cnt - CW'(1);
      end
    end
    last1 <= (cnt == CW'(1));
    j1    <= j;
    last2 <= last1;
    j2    <= j1;
    prod  <= lq * rq;
  end

  assign acc_next = (acc_clr ? '0 : acc) + CORR_W'(prod);

  always_ff @(posedge clk) begin
    if (start) begin
      acc_clr  <= 1'b1;
      best     <= '0;
      best_idx <= '0;
      found    <= 1'b0;
    end else begin
      if (v2) begin
        acc     <= acc_next;
        acc_clr <= last2;
        if (last2) begin
          sum <= acc_next;
          sj  <= j2;
        end
      end
      if (sv && sum > best) begin
        best     <= sum;
        best_idx <= sj;
        found    <= 1'b1;
      end
    end
  end

  assign done = running && !start && !issuing && !v1 && !v2 && !sv;

  always_comb begin
    itd_full = $signed({2'b00, nq}) - (XW + 1)'(1) - $signed({1'b0, best_idx});
    lim      = $signed((XW + 1)'(max_lag));
    if (itd_full > lim)
      itd_c = lim;
    else if (itd_full < -lim)
      itd_c = -lim;
    else
      itd_c = itd_full;
    idx_w        = IW'(best_idx);
    result.itd   = itd_c[OUT_W-1:0];
    result.idx   = idx_w[OUT_W-1:0];
    result.found = found;
  end

endmodule
`default_nettype wire

// ===== rtl/ide_checker.sv =====
// Port-level assertions for interaural_delay_estimator, with the bind that attaches them.
// Depends on ide_pkg.
`default_nettype none
module ide_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             last_sample,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [ide_pkg::OUT_W-1:0] itd_samples,
  input logic [ide_pkg::OUT_W-1:0]        peak_index,
  input logic                             peak_found
);
  import ide_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(itd_samples) && $stable(peak_index))
    else $error("result changed while stalled");

  a_no_peak_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && !peak_found |-> peak_index == '0)
    else $error("peak index set without a peak");

  a_itd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> itd_samples != 9'h100)
    else $error("lag outside clamp range");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_sample |=> !in_ready)
    else $error("request taken while run is closing");

endmodule

bind interaural_delay_estimator ide_checker u_ide_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .last_sample(last_sample), .out_valid(out_valid), .out_ready(out_ready),
  .itd_samples(itd_samples), .peak_index(peak_index), .peak_found(peak_found)
);
`default_nettype wire

// ===== tb/sv/interaural_delay_estimator_test.sv =====
// Self-checking test of interaural_delay_estimator: sample-pair runs go in, delay results come out.
// Biquad filtering and correlation are predicted in the bench; depends on ide_pkg and the RTL.
`default_nettype none
module interaural_delay_estimator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ide_pkg::*;

  localparam int STORE_LEN = 256;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [OUT_W-1:0] itd;
    logic [OUT_W-1:0]        idx;
    logic                    found;
    logic                    ovf;
  } itd_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic signed [SAMPLE_W-1:0] left_sample = '0, right_sample = '0;
  logic last_sample = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic signed [OUT_W-1:0] itd_samples;
  logic [OUT_W-1:0] peak_index;
  logic peak_found, length_overflow;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  interaural_delay_estimator i_dut (.*);

  // bench copy of the block
  coef_t                      coefs;
  logic [LAG_W-1:0]           lag_limit;
  logic signed [STORE_W-1:0]  left_store [STORE_LEN];
  logic signed [STORE_W-1:0]  right_store [STORE_LEN];
  logic signed [DELAY_W-1:0]  ld1, ld2, rd1, rd2;
  int                         stored_pairs;
  logic                       dropped;

  itd_result_t pending_itd[$];
  int  send_idle_pct = 0, recv_stall_pct = 0;
  logic stall_hold = 1'b0;
  int  errors = 0, runs_sent = 0, pairs_sent = 0, results_seen = 0, ovf_runs = 0;
  int  quiet_cycles = 0;

  initial forever #6 clk = ~clk;

  function automatic longint round_q22(longint v);
    return (v + (64'sd1 <<< 21)) >>> 22;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic logic signed [STORE_W-1:0] biquad_step(
      logic signed [SAMPLE_W-1:0] x, inout logic signed [DELAY_W-1:0] d1,
      inout logic signed [DELAY_W-1:0] d2);
    longint acc;
    logic signed [DELAY_W-1:0] w;
    acc = (longint'(x) <<< 27) - longint'(coefs.a1) * d1 - longint'(coefs.a2) * d2;
    w = DELAY_W'(clip(round_q22(acc), DELAY_W));
    acc = longint'(coefs.b0) * w + longint'(coefs.b1) * d1 + longint'(coefs.b2) * d2;
    d2 = d1;
    d1 = w;
    return STORE_W'(clip(round_q22(acc), STORE_W));
  endfunction

  task automatic predict_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                              logic fin);
    longint n_len, best_val, acc, itd, lim;
    int best_idx;
    logic hit;
    itd_result_t res;
    if (stored_pairs < STORE_LEN) begin
      left_store[stored_pairs] = biquad_step(l, ld1, ld2);
      right_store[stored_pairs] = biquad_step(r, rd1, rd2);
      stored_pairs++;
    end else begin
      dropped = 1'b1;
    end
    if (!fin) return;
    n_len = stored_pairs;
    best_val = 0;
    best_idx = 0;
    hit = 1'b0;
    for (int j = 0; j < 2 * n_len - 1; j++) begin
      acc = 0;
      for (int n = 0; n < n_len; n++) begin
        int m;
        m = int'(n + j - (n_len - 1));
        if (m >= 0 && m < n_len) acc += longint'(left_store[m]) * right_store[n];
      end
      if (acc > best_val) begin
        best_val = acc;
        best_idx = j;
        hit = 1'b1;
      end
    end
    itd = n_len - 1 - best_idx;
    lim = lag_limit;
    if (itd > lim) itd = lim;
    if (itd < -lim) itd = -lim;
    res.itd = OUT_W'(itd);
    res.idx = OUT_W'(best_idx);
    res.found = hit;
    res.ovf = dropped;
    pending_itd.push_back(res);
    if (dropped) ovf_runs++;
    runs_sent++;
    ld1 = '0; ld2 = '0; rd1 = '0; rd2 = '0;
    stored_pairs = 0;
    dropped = 1'b0;
  endtask

  task automatic send_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                           logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    left_sample <= l;
    right_sample <= r;
    last_sample <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
    predict_pair(l, r, fin);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_itd.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_B0:      coefs.b0 = data;
      REG_B1:      coefs.b1 = data;
      REG_B2:      coefs.b2 = data;
      REG_A1:      coefs.a1 = data;
      REG_A2:      coefs.a2 = data;
      REG_MAX_LAG: lag_limit = data[LAG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_coefs(int b0, int b1, int b2, int a1, int a2);
    write_reg(REG_B0, COEF_W'(b0));
    write_reg(REG_B1, COEF_W'(b1));
    write_reg(REG_B2, COEF_W'(b2));
    write_reg(REG_A1, COEF_W'(a1));
    write_reg(REG_A2, COEF_W'(a2));
  endtask

  // one run of len pairs; shape picks noise, delayed copy, impulses or small values
  task automatic send_run(int len, int shape);
    logic signed [SAMPLE_W-1:0] l [$];
    logic signed [SAMPLE_W-1:0] r [$];
    int shift;
    shift = $urandom_range(len - 1);
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: begin
          l.push_back(SAMPLE_W'($urandom));
          r.push_back(SAMPLE_W'($urandom));
        end
        1: l.push_back(SAMPLE_W'($urandom));
        2: begin
          l.push_back(i == 0 ? 16'sh7fff : 16'sh0);
          r.push_back(i == shift ? 16'sh7fff : 16'sh0);
        end
        default: begin
          l.push_back(SAMPLE_W'($signed($urandom_range(15)) - 8));
          r.push_back(SAMPLE_W'($signed($urandom_range(15)) - 8));
        end
      endcase
    end
    if (shape == 1)
      for (int i = 0; i < len; i++)
        r.push_back(i >= shift ? l[i - shift] : SAMPLE_W'($urandom_range(3)));
    for (int i = 0; i < len; i++) send_pair(l[i], r[i], i == len - 1);
  endtask

  task automatic test_directed();
    send_pair(16'sh7fff, -16'sh8000, 1'b1);
    send_pair(16'sh0, 16'sh0, 1'b0);
    send_pair(16'sh0, 16'sh0, 1'b0);
    send_pair(16'sh0, 16'sh0, 1'b1);
    send_pair(16'sh7fff, 16'sh0, 1'b0);
    send_pair(16'sh0, 16'sh0, 1'b0);
    send_pair(16'sh0, 16'sh7fff, 1'b0);
    send_pair(16'sh0, 16'sh0, 1'b1);
    send_pair(-16'sh8000, -16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b0);
    send_pair(-16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sh7fff, -16'sh8000, 1'b1);
    send_pair(16'sh4000, -16'sh4000, 1'b0);
    send_pair(16'sh2000, -16'sh2000, 1'b0);
    send_pair(-16'sh1000, 16'sh1000, 1'b1);
    drain();
  endtask

  task automatic test_registers();
    write_reg(REG_MAX_LAG, 24'h000000);
    send_run(6, 2);
    drain();
    write_reg(REG_MAX_LAG, 24'hA5_00FF);
    send_run(8, 1);
    drain();
    load_coefs(8388607, -8388608, 0, -8388608, 8388607);
    send_run(6, 0);
    drain();
    load_coefs(-8388608, 8388607, -8388608, 8388607, -8388608);
    send_run(5, 0);
    drain();
    write_reg(REG_SPARE_LO, 24'hFFFFFF);
    write_reg(REG_SPARE_HI, 24'h123456);
    write_reg(REG_MAX_LAG, 24'h000002);
    load_coefs(9444, 18889, 9444, -7807060, 3650583);
    send_run(7, 1);
    drain();
  endtask

  task automatic test_store_limit();
    write_reg(REG_MAX_LAG, 24'h0000FF);
    send_run(STORE_LEN, 1);
    send_run(STORE_LEN + 3, 0);
    send_run(2, 2);
    drain();
  endtask

  task automatic test_random(int pairs, int idle, int stall);
    int goal;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    goal = pairs_sent + pairs;
    while (pairs_sent < goal) begin
      if ($urandom_range(5) == 0) begin
        drain();
        write_reg(REG_MAX_LAG, COEF_W'($urandom_range(40)));
        if ($urandom_range(3) == 0)
          load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
        else
          load_coefs(9444, 18889, 9444, -7807060, 3650583);
      end
      send_run($urandom_range(19) == 0 ? $urandom_range(40, 70) : $urandom_range(1, 20),
               $urandom_range(3));
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        stall_hold <= 1'b1;
        repeat (3000) @(posedge clk);
        stall_hold <= 1'b0;
      end
      for (int k = 0; k < 4; k++) send_run(4, k);
    join
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !stall_hold && ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_itd.size() == 0) begin
          errors++;
          $display("%t: unexpected result itd=%0d idx=%0d", $realtime, itd_samples, peak_index);
        end else begin
          itd_result_t want;
          want = pending_itd.pop_front();
          if (itd_samples !== want.itd) begin
            errors++;
            $display("%t: itd_samples expected %0d actual %0d", $realtime, want.itd, itd_samples);
          end
          if (peak_index !== want.idx) begin
            errors++;
            $display("%t: peak_index expected %0d actual %0d", $realtime, want.idx, peak_index);
          end
          if (peak_found !== want.found) begin
            errors++;
            $display("%t: peak_found expected %0b actual %0b", $realtime, want.found, peak_found);
          end
          if (length_overflow !== want.ovf) begin
            errors++;
            $display("%t: length_overflow expected %0b actual %0b", $realtime, want.ovf,
                     length_overflow);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%t: timeout, %0d results outstanding", $realtime, pending_itd.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    coefs = '{b0: 9444, b1: 18889, b2: 9444, a1: -7807060, a2: 3650583};
    lag_limit = 33;
    ld1 = '0; ld2 = '0; rd1 = '0; rd2 = '0;
    stored_pairs = 0;
    dropped = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_registers();
    test_store_limit();
    test_random(120, 0, 0);
    test_random(120, 48, 0);
    test_random(120, 0, 48);
    test_random(120, 21, 21);
    test_backpressure();
    $display("Covered %0d runs, %0d pairs, %0d results, %0d with dropped pairs.",
             runs_sent, pairs_sent, results_seen, ovf_runs);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
